### rtl/vec_pkg.sv
package vec_pkg;

  // width of each coordinate field
  localparam int unsigned CoordW = 4;

  // default grid size
  localparam int unsigned GridXDef = 16;
  localparam int unsigned GridYDef = 16;
  localparam int unsigned GridZDef = 16;

  // command codes, the spare code behaves as a read
  typedef enum logic [1:0] {
    CmdWrOcc    = 2'd0,
    CmdClassify = 2'd1,
    CmdRdVis    = 2'd2
  } cmd_e;

  // transaction held between the memory read and the result register
  typedef struct packed {
    logic              classify;
    logic              in_range;
    logic              fwd_hit;
    logic              fwd_val;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
  } item_t;

endpackage

### rtl/vec_ram.sv
module vec_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256,
  parameter int unsigned NumRd = 1,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wmask_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i [NumRd],
  output logic [Width-1:0] rdata_o [NumRd]
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q [NumRd];

  // bit-masked write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < Width; b++) begin
        if (wmask_i[b]) begin
          mem_q[waddr_i][b] <= wdata_i[b];
        end
      end
    end
  end

  // registered read ports, old data on a same-edge write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      for (int p = 0; p < NumRd; p++) begin
        rdata_q[p] <= mem_q[raddr_i[p]];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/vec_clear.sv
module vec_clear #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  output logic             busy_o,
  output logic [AddrW-1:0] addr_o
);

  localparam logic [AddrW-1:0] LastRow = AddrW'(Depth - 1);

  logic             busy_d, busy_q;
  logic [AddrW-1:0] addr_d, addr_q;

  // one row per cycle until the last row is written
  always_comb begin
    busy_d = busy_q;
    addr_d = addr_q;
    if (busy_q) begin
      if (addr_q == LastRow) begin
        busy_d = 1'b0;
      end else begin
        addr_d = addr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      addr_q <= '0;
    end else begin
      busy_q <= busy_d;
      addr_q <= addr_d;
    end
  end

  assign busy_o = busy_q;
  assign addr_o = addr_q;

endmodule

### rtl/vec_exposure.sv
module vec_exposure #(
  parameter int unsigned GRID_X = vec_pkg::GridXDef,
  parameter int unsigned GRID_Y = vec_pkg::GridYDef,
  parameter int unsigned GRID_Z = vec_pkg::GridZDef
) (
  input  vec_pkg::item_t      item_i,
  input  logic [GRID_Z-1:0]   row_c_i,
  input  logic [GRID_Z-1:0]   row_xm_i,
  input  logic [GRID_Z-1:0]   row_xp_i,
  input  logic [GRID_Z-1:0]   row_ym_i,
  input  logic [GRID_Z-1:0]   row_yp_i,
  output logic                exposed_o
);

  localparam int unsigned ZiW = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;

  logic [ZiW-1:0] zi, zm_idx, zp_idx;
  logic           has_xm, has_xp, has_ym, has_yp, has_zm, has_zp;
  logic           solid, enclosed;

  // which face neighbours lie inside the grid
  always_comb begin
    zi     = ZiW'(item_i.z);
    has_xm = (item_i.x != '0);
    has_xp = (int'(item_i.x) < int'(GRID_X) - 1);
    has_ym = (item_i.y != '0);
    has_yp = (int'(item_i.y) < int'(GRID_Y) - 1);
    has_zm = (zi != '0);
    has_zp = (int'(zi) < int'(GRID_Z) - 1);
    zm_idx = has_zm ? zi - ZiW'(1) : zi;
    zp_idx = has_zp ? zi + ZiW'(1) : zi;
  end

  // exposed only when solid and not boxed in on all six faces
  always_comb begin
    solid    = row_c_i[zi];
    enclosed = has_xm && row_xm_i[zi] &&
               has_xp && row_xp_i[zi] &&
               has_ym && row_ym_i[zi] &&
               has_yp && row_yp_i[zi] &&
               has_zm && row_c_i[zm_idx] &&
               has_zp && row_c_i[zp_idx];
    exposed_o = solid && !enclosed;
  end

endmodule

### rtl/voxel_exposure_classifier_core.sv
// Voxel exposure classifier. Holds one occupancy bit and one visibility bit per voxel of a
// GRID_X by GRID_Y by GRID_Z grid, both stored as rows of GRID_Z bits, one row per (x, y).
// Command 0 writes occupancy, command 1 classifies the voxel from its own and its six face
// neighbours' occupancy and stores the answer, commands 2 and 3 read. Every transaction
// returns one result: the voxel's visibility after the command, or 0 for a coordinate
// outside the grid. A transaction is taken every cycle unless in_stall_o is high. The
// accepting edge does the registered memory read into stage one, and the result moves on
// to the output register when it is free. Five occupancy rows are read per classification
// from three occupancy memory copies. After reset a clearing pass over all GRID_X * GRID_Y
// rows sets every voxel occupied and hidden; no input is taken during it.
module voxel_exposure_classifier_core #(
  parameter int unsigned GRID_X = vec_pkg::GridXDef,
  parameter int unsigned GRID_Y = vec_pkg::GridYDef,
  parameter int unsigned GRID_Z = vec_pkg::GridZDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 cmd_i,
  input  logic [vec_pkg::CoordW-1:0] voxel_x_i,
  input  logic [vec_pkg::CoordW-1:0] voxel_y_i,
  input  logic [vec_pkg::CoordW-1:0] voxel_z_i,
  input  logic                       occupied_in_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       visible_out_o
);

  localparam int unsigned Rows = GRID_X * GRID_Y;
  localparam int unsigned AW   = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned ZiW  = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
  localparam logic [GRID_Z-1:0] ZOne = GRID_Z'(1);

  // clearing pass
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  vec_clear #(
    .Depth (Rows)
  ) u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_o (clr_busy),
    .addr_o (clr_addr)
  );

  // handshake
  logic           accept, out_free, s1_adv;
  logic           s1_valid_d, s1_valid_q;
  logic           out_valid_d, out_valid_q;
  logic           visible_d, visible_q;
  vec_pkg::item_t s1_d, s1_q;
  logic [AW-1:0]  s1_addr_q;
  logic           exposed;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = clr_busy || (s1_valid_q && !out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // input side decode and row addresses
  logic          in_range, wr_occ;
  logic [ZiW-1:0] in_zi;
  logic [AW-1:0] a_c, a_xm, a_xp, a_ym, a_yp;

  always_comb begin
    in_range = (int'(voxel_x_i) < int'(GRID_X)) &&
               (int'(voxel_y_i) < int'(GRID_Y)) &&
               (int'(voxel_z_i) < int'(GRID_Z));
    wr_occ   = in_range && (cmd_i == vec_pkg::CmdWrOcc);
    in_zi    = ZiW'(voxel_z_i);
    a_c      = AW'(voxel_x_i) * AW'(GRID_Y) + AW'(voxel_y_i);
    a_xm     = (voxel_x_i != '0) ? a_c - AW'(GRID_Y) : a_c;
    a_xp     = (int'(voxel_x_i) < int'(GRID_X) - 1) ? a_c + AW'(GRID_Y) : a_c;
    a_ym     = (voxel_y_i != '0) ? a_c - AW'(1) : a_c;
    a_yp     = (int'(voxel_y_i) < int'(GRID_Y) - 1) ? a_c + AW'(1) : a_c;
  end

  // occupancy write, at acceptance or from the clearing pass
  logic              occ_we;
  logic [AW-1:0]     occ_waddr;
  logic [GRID_Z-1:0] occ_wmask, occ_wdata;

  always_comb begin
    occ_we    = clr_busy || (accept && wr_occ);
    occ_waddr = clr_busy ? clr_addr : a_c;
    occ_wmask = clr_busy ? '1 : (ZOne << in_zi);
    occ_wdata = clr_busy ? '1 : {GRID_Z{occupied_in_i}};
  end

  // three occupancy copies cover the five row reads
  logic [AW-1:0]     occ_a_raddr [2];
  logic [AW-1:0]     occ_b_raddr [2];
  logic [AW-1:0]     occ_c_raddr [1];
  logic [GRID_Z-1:0] occ_a_rdata [2];
  logic [GRID_Z-1:0] occ_b_rdata [2];
  logic [GRID_Z-1:0] occ_c_rdata [1];

  assign occ_a_raddr[0] = a_c;
  assign occ_a_raddr[1] = a_xm;
  assign occ_b_raddr[0] = a_xp;
  assign occ_b_raddr[1] = a_ym;
  assign occ_c_raddr[0] = a_yp;

  vec_ram #(.Width(GRID_Z), .Depth(Rows), .NumRd(2)) u_occ_a (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wmask_i (occ_wmask),
    .wdata_i (occ_wdata),
    .re_i    (accept),
    .raddr_i (occ_a_raddr),
    .rdata_o (occ_a_rdata)
  );

  vec_ram #(.Width(GRID_Z), .Depth(Rows), .NumRd(2)) u_occ_b (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wmask_i (occ_wmask),
    .wdata_i (occ_wdata),
    .re_i    (accept),
    .raddr_i (occ_b_raddr),
    .rdata_o (occ_b_rdata)
  );

  vec_ram #(.Width(GRID_Z), .Depth(Rows), .NumRd(1)) u_occ_c (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wmask_i (occ_wmask),
    .wdata_i (occ_wdata),
    .re_i    (accept),
    .raddr_i (occ_c_raddr),
    .rdata_o (occ_c_rdata)
  );

  // visibility memory, written by the clearing pass or when an in-range classification leaves stage one
  logic              vis_we;
  logic [AW-1:0]     vis_waddr;
  logic [GRID_Z-1:0] vis_wmask, vis_wdata;
  logic [AW-1:0]     vis_raddr [1];
  logic [GRID_Z-1:0] vis_rdata [1];
  logic [ZiW-1:0]    s1_zi;

  assign s1_zi        = ZiW'(s1_q.z);
  assign vis_raddr[0] = a_c;

  always_comb begin
    vis_we    = clr_busy || (s1_adv && s1_q.classify && s1_q.in_range);
    vis_waddr = clr_busy ? clr_addr : s1_addr_q;
    vis_wmask = clr_busy ? '1 : (ZOne << s1_zi);
    vis_wdata = clr_busy ? '0 : {GRID_Z{exposed}};
  end

  vec_ram #(.Width(GRID_Z), .Depth(Rows), .NumRd(1)) u_vis (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wmask_i (vis_wmask),
    .wdata_i (vis_wdata),
    .re_i    (accept),
    .raddr_i (vis_raddr),
    .rdata_o (vis_rdata)
  );

  // exposure test on the rows read for stage one
  vec_exposure #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_exposure (
    .item_i    (s1_q),
    .row_c_i   (occ_a_rdata[0]),
    .row_xm_i  (occ_a_rdata[1]),
    .row_xp_i  (occ_b_rdata[0]),
    .row_ym_i  (occ_b_rdata[1]),
    .row_yp_i  (occ_c_rdata[0]),
    .exposed_o (exposed)
  );

  // stage one load, with forwarding of a visibility write the read missed
  always_comb begin
    s1_d.classify = (cmd_i == vec_pkg::CmdClassify);
    s1_d.in_range = in_range;
    s1_d.fwd_hit  = s1_valid_q && s1_q.classify && s1_q.in_range &&
                    (s1_q.x == voxel_x_i) && (s1_q.y == voxel_y_i) &&
                    (s1_q.z == voxel_z_i);
    s1_d.fwd_val  = exposed;
    s1_d.x        = voxel_x_i;
    s1_d.y        = voxel_y_i;
    s1_d.z        = voxel_z_i;
    s1_valid_d    = accept || (s1_valid_q && !out_free);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q      <= s1_d;
      s1_addr_q <= a_c;
    end
  end

  // result of the transaction in stage one
  always_comb begin
    out_valid_d = out_valid_q;
    visible_d   = visible_q;
    if (out_free) begin
      out_valid_d = s1_valid_q;
      priority if (!s1_q.in_range) begin
        visible_d = 1'b0;
      end else if (s1_q.classify) begin
        visible_d = exposed;
      end else if (s1_q.fwd_hit) begin
        visible_d = s1_q.fwd_val;
      end else begin
        visible_d = vis_rdata[0][s1_zi];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    visible_q <= visible_d;
  end

  assign out_valid_o   = out_valid_q;
  assign visible_out_o = visible_q;

endmodule

### tb/sv/tb_voxel_exposure_classifier_core.sv
`timescale 1ns / 100ps

module tb_voxel_exposure_classifier_core;

  localparam int GridX = int'(vec_pkg::GridXDef);
  localparam int GridY = int'(vec_pkg::GridYDef);
  localparam int GridZ = int'(vec_pkg::GridZDef);
  localparam int unsigned CoordW = vec_pkg::CoordW;
  localparam int VoxelCount = GridX * GridY * GridZ;
  localparam int RandomItems = 1650;
  localparam int TailItems = 200;
  localparam int CycleLimit = 400000;
  localparam logic [1:0] CmdSpare = 2'd3;

  typedef struct {
    logic [1:0]        cmd;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic              occ;
    bit                drain_first;
  } voxel_cmd_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        cmd_i = vec_pkg::CmdRdVis;
  logic [CoordW-1:0] voxel_x_i = '0;
  logic [CoordW-1:0] voxel_y_i = '0;
  logic [CoordW-1:0] voxel_z_i = '0;
  logic              occupied_in_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              visible_out_o;

  // predictor state
  bit occ_map [VoxelCount];
  bit vis_map [VoxelCount];

  voxel_cmd_t pending_cmds[$];
  bit         visibility_due[$];

  bit in_taken = 1'b0;
  bit tail_phase = 1'b0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int errors = 0;
  int cycle_count = 0;

  voxel_exposure_classifier_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .voxel_x_i     (voxel_x_i),
    .voxel_y_i     (voxel_y_i),
    .voxel_z_i     (voxel_z_i),
    .occupied_in_i (occupied_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .visible_out_o (visible_out_o)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int voxel_idx(int x, int y, int z);
    return (x * GridY + y) * GridZ + z;
  endfunction

  // cells outside the grid count as empty
  function automatic bit solid_at(int x, int y, int z);
    if (x < 0 || y < 0 || z < 0 || x >= GridX || y >= GridY || z >= GridZ) return 1'b0;
    return occ_map[voxel_idx(x, y, z)];
  endfunction

  function automatic bit exposed_now(int x, int y, int z);
    if (!solid_at(x, y, z)) return 1'b0;
    return !(solid_at(x - 1, y, z) && solid_at(x + 1, y, z) &&
             solid_at(x, y - 1, z) && solid_at(x, y + 1, z) &&
             solid_at(x, y, z - 1) && solid_at(x, y, z + 1));
  endfunction

  // applies one transaction to the predictor state, returns the visibility seen
  function automatic bit predict_visibility(logic [1:0] cmd, int x, int y, int z, bit occ);
    int idx;
    if (x >= GridX || y >= GridY || z >= GridZ) return 1'b0;
    idx = voxel_idx(x, y, z);
    if (cmd == vec_pkg::CmdWrOcc) occ_map[idx] = occ;
    else if (cmd == vec_pkg::CmdClassify) vis_map[idx] = exposed_now(x, y, z);
    return vis_map[idx];
  endfunction

  task automatic push_cmd(logic [1:0] cmd, int x, int y, int z, bit occ);
    voxel_cmd_t c;
    c.cmd = cmd;
    c.x = CoordW'(x);
    c.y = CoordW'(y);
    c.z = CoordW'(z);
    c.occ = occ;
    c.drain_first = 1'b0;
    pending_cmds.push_back(c);
  endtask

  // write part of a small box, sweep-classify it, then read some of it back
  task automatic add_region();
    int x0, y0, z0, x1, y1, z1;
    x0 = $urandom_range(0, GridX - 1);
    y0 = $urandom_range(0, GridY - 1);
    z0 = $urandom_range(0, GridZ - 1);
    x1 = x0 + $urandom_range(0, 2);
    y1 = y0 + $urandom_range(0, 2);
    z1 = z0 + $urandom_range(0, 2);
    if (x1 >= GridX) x1 = GridX - 1;
    if (y1 >= GridY) y1 = GridY - 1;
    if (z1 >= GridZ) z1 = GridZ - 1;
    for (int x = x0; x <= x1; x++)
      for (int y = y0; y <= y1; y++)
        for (int z = z0; z <= z1; z++)
          if ($urandom_range(0, 1) == 0)
            push_cmd(vec_pkg::CmdWrOcc, x, y, z, $urandom_range(0, 3) != 0);
    for (int x = x0; x <= x1; x++)
      for (int y = y0; y <= y1; y++)
        for (int z = z0; z <= z1; z++)
          push_cmd(vec_pkg::CmdClassify, x, y, z, 1'($urandom_range(0, 1)));
    repeat (3) begin
      push_cmd($urandom_range(0, 3) == 0 ? CmdSpare : vec_pkg::CmdRdVis,
               $urandom_range(x0, x1), $urandom_range(y0, y1), $urandom_range(z0, z1),
               1'($urandom_range(0, 1)));
    end
  endtask

  // stimulus, reset and end of run
  initial begin
    int directed_n;
    foreach (occ_map[i]) occ_map[i] = 1'b1;
    foreach (vis_map[i]) vis_map[i] = 1'b0;

    // freshly reset grid, corners, faces and an interior voxel
    push_cmd(vec_pkg::CmdRdVis, 0, 0, 0, 1'b0);
    push_cmd(vec_pkg::CmdClassify, 5, 5, 5, 1'b1);
    push_cmd(vec_pkg::CmdClassify, 0, 0, 0, 1'b0);
    push_cmd(vec_pkg::CmdClassify, 15, 15, 15, 1'b1);
    push_cmd(vec_pkg::CmdClassify, 15, 7, 7, 1'b0);
    push_cmd(vec_pkg::CmdClassify, 7, 0, 7, 1'b0);
    push_cmd(vec_pkg::CmdClassify, 7, 7, 15, 1'b0);
    // empty voxel is hidden, its neighbour becomes exposed
    push_cmd(vec_pkg::CmdWrOcc, 7, 7, 7, 1'b0);
    push_cmd(vec_pkg::CmdClassify, 7, 7, 7, 1'b1);
    push_cmd(vec_pkg::CmdClassify, 7, 7, 8, 1'b0);
    push_cmd(vec_pkg::CmdRdVis, 7, 7, 8, 1'b0);
    // refilling does not touch stored visibility until reclassified
    push_cmd(vec_pkg::CmdWrOcc, 7, 7, 7, 1'b1);
    push_cmd(vec_pkg::CmdRdVis, 7, 7, 8, 1'b1);
    push_cmd(vec_pkg::CmdClassify, 7, 7, 8, 1'b0);
    push_cmd(vec_pkg::CmdRdVis, 7, 7, 8, 1'b0);
    // spare code reads
    push_cmd(CmdSpare, 0, 0, 0, 1'b1);
    push_cmd(CmdSpare, 15, 15, 15, 1'b0);
    // empty corner voxel stays hidden, refilled it classifies exposed and is read back
    push_cmd(vec_pkg::CmdWrOcc, 15, 0, 15, 1'b0);
    push_cmd(vec_pkg::CmdClassify, 15, 0, 15, 1'b1);
    push_cmd(vec_pkg::CmdWrOcc, 15, 0, 15, 1'b1);
    push_cmd(vec_pkg::CmdClassify, 15, 0, 15, 1'b0);
    push_cmd(vec_pkg::CmdRdVis, 15, 0, 15, 1'b1);
    directed_n = pending_cmds.size();

    // random part: mostly region sweeps, some noise
    while (pending_cmds.size() < directed_n + RandomItems) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat (8) push_cmd(2'($urandom_range(0, 3)), $urandom_range(0, GridX - 1),
                            $urandom_range(0, GridY - 1), $urandom_range(0, GridZ - 1),
                            1'($urandom_range(0, 1)));
      end else begin
        add_region();
      end
    end
    pending_cmds[directed_n].drain_first = 1'b1;
    pending_cmds[pending_cmds.size() / 2].drain_first = 1'b1;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid_i || visibility_due.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && visibility_due.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      in_taken = 1'b0;
      if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_cmds.size() != 0 &&
                   !(pending_cmds[0].drain_first && visibility_due.size() != 0)) begin
        voxel_cmd_t c;
        c = pending_cmds.pop_front();
        tail_phase = pending_cmds.size() < TailItems;
        in_valid_i    <= 1'b1;
        cmd_i         <= c.cmd;
        voxel_x_i     <= c.x;
        voxel_y_i     <= c.y;
        voxel_z_i     <= c.z;
        occupied_in_i <= c.occ;
        if (!tail_phase && !in_calm && $urandom_range(0, 5) == 0)
          gap_left = $urandom_range(1, 10);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output stall driver
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
    if (stall_left == 0 && !tail_phase && !out_calm && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 10);
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // accepted transactions feed the predictor, results are checked in order
  always @(posedge clk_i) begin
    bit want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        visibility_due.push_back(predict_visibility(cmd_i, int'(voxel_x_i), int'(voxel_y_i),
                                                    int'(voxel_z_i), occupied_in_i));
        in_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (visibility_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result visible_out=%b", visible_out_o);
        end else begin
          want = visibility_due.pop_front();
          if (visible_out_o !== want) begin
            errors++;
            if (errors <= 10)
              $display("visible_out mismatch: expected %b actual %b", want, visible_out_o);
          end
        end
      end
    end
  end

endmodule

### sim.f
rtl/vec_pkg.sv
rtl/vec_ram.sv
rtl/vec_clear.sv
rtl/vec_exposure.sv
rtl/voxel_exposure_classifier_core.sv
tb/sv/tb_voxel_exposure_classifier_core.sv
